/* design/qrs_pkg.sv */
// Package for the quadratic root solver: root kind codes, lane count and
// the fixed-point shifts of the Q8.8 in / Q16.16 out formats. No dependencies.
package qrs_pkg;

   typedef enum logic [1:0] {
      KIND_DISTINCT = 2'd0,
      KIND_REPEATED = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_INVALID  = 2'd3
   } root_kind_type;

   // Divider lanes: first real, second real, imaginary
   localparam int ROOT_LANES = 3;

   // Discriminant is Q16.16; radicand gets 16 more fraction bits
   localparam int RAD_SHIFT  = 16;
   // -b in Q8.8 to Q16.16
   localparam int NEGB_SHIFT = 8;
   // Q16.16 numerator over 2a in Q8.8 gives a factor of 128
   localparam int QUOT_SHIFT = 7;

endpackage

/* design/qrs_sqrt_cell.sv */
// One digit cell of the pipelined restoring square root: two radicand bits
// in, one root bit out, per stage. No package dependency.
module qrs_sqrt_cell #(
   parameter int RADW  = 50,
   parameter int RS    = 25,
   parameter int SIDEW = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [RADW-1:0]  in_rad,
   input  logic [RS+2:0]    in_rem,
   input  logic [RS-1:0]    in_root,
   input  logic [SIDEW-1:0] in_side,
   output logic             out_valid,
   output logic [RADW-1:0]  out_rad,
   output logic [RS+2:0]    out_rem,
   output logic [RS-1:0]    out_root,
   output logic [SIDEW-1:0] out_side
);

   logic             valid_ff;
   logic [RADW-1:0]  rad_ff, rad_in;
   logic [RS+2:0]    rem_ff, rem_in;
   logic [RS-1:0]    root_ff, root_in;
   logic [SIDEW-1:0] side_ff;
   logic [RS+2:0]    rem_sh, trial;
   logic             ge;

   // remainder stays below 2^(RS+1), so the top bits drop safely
   assign rem_sh  = {in_rem[RS:0], in_rad[RADW-1 -: 2]};
   assign trial   = {1'b0, in_root, 2'b01};
   assign ge      = (rem_sh >= trial);
   assign rem_in  = ge ? (rem_sh - trial) : rem_sh;
   assign root_in = {in_root[RS-2:0], ge};
   assign rad_in  = {in_rad[RADW-3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

/* design/qrs_div_cell.sv */
// One bit cell of the pipelined restoring divider, three lanes sharing one
// divisor. Depends on qrs_pkg for the lane count.
module qrs_div_cell #(
   parameter int QW    = 34,
   parameter int DVW   = 16,
   parameter int SIDEW = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   in_valid,
   input  logic [qrs_pkg::ROOT_LANES-1:0][QW-1:0]  in_dq,
   input  logic [qrs_pkg::ROOT_LANES-1:0][DVW-1:0] in_rem,
   input  logic [DVW-1:0]                         in_div,
   input  logic [SIDEW-1:0]                       in_side,
   output logic                                   out_valid,
   output logic [qrs_pkg::ROOT_LANES-1:0][QW-1:0]  out_dq,
   output logic [qrs_pkg::ROOT_LANES-1:0][DVW-1:0] out_rem,
   output logic [DVW-1:0]                         out_div,
   output logic [SIDEW-1:0]                       out_side
);
   import qrs_pkg::*;

   logic                            valid_ff;
   logic [ROOT_LANES-1:0][QW-1:0]   dq_ff, dq_in;
   logic [ROOT_LANES-1:0][DVW-1:0]  rem_ff, rem_in;
   logic [DVW-1:0]                  div_ff;
   logic [SIDEW-1:0]                side_ff;
   logic [ROOT_LANES-1:0][DVW:0]    part, diff;
   logic [ROOT_LANES-1:0]           ge;

   // shift one dividend bit into the remainder, subtract if it fits
   always_comb begin
      for (int l = 0; l < ROOT_LANES; l++) begin
         part[l]   = {in_rem[l], in_dq[l][QW-1]};
         diff[l]   = part[l] - {1'b0, in_div};
         ge[l]     = (part[l] >= {1'b0, in_div});
         rem_in[l] = ge[l] ? diff[l][DVW-1:0] : part[l][DVW-1:0];
         dq_in[l]  = {in_dq[l][QW-2:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dq_ff   <= dq_in;
         rem_ff  <= rem_in;
         div_ff  <= in_div;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_dq    = dq_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

/* design/quadratic_root_solver_top.sv */
// Quadratic root solver top level: front end, square-root cell chain,
// divider cell chain and output stage. Depends on qrs_pkg, qrs_sqrt_cell,
// qrs_div_cell.
//
// Usage:
//   A request carries signed Q8.8 coefficients a, b, c on req_coef_*. It is
//   taken at a clock edge where req_valid is high and req_stall is low.
//   Each request yields exactly one response on rsp_*: the root kind, both
//   roots as saturated signed Q16.16 real/imaginary parts, and a clip flag.
//   The response is taken where rsp_valid is high and rsp_stall is low.
// Throughput: one request per cycle while req_stall is low, with no gaps.
// Pipeline: front-end registers, then RS square-root cells (one root bit
//   each), numerator registers, QW divider cells (one quotient bit each),
//   the sign-and-saturate register and the response register.
// Stall: while a response is held and rsp_stall is high, the whole pipeline
//   freezes and req_stall is raised; bubbles in the pipeline still collapse
//   nothing, so nothing is lost or repeated.
// Reset: synchronous, clears every stage valid; no response is pending
//   afterwards. There is no configuration and no stored state across items.
module quadratic_root_solver_top #(
   parameter int COEF_WIDTH = 16,
   parameter int ROOT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_a,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_b,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_c,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output qrs_pkg::root_kind_type        rsp_root_kind,
   output logic signed [ROOT_WIDTH-1:0]  rsp_first_real,
   output logic signed [ROOT_WIDTH-1:0]  rsp_first_imag,
   output logic signed [ROOT_WIDTH-1:0]  rsp_second_real,
   output logic signed [ROOT_WIDTH-1:0]  rsp_second_imag,
   output logic                          rsp_clipped
);
   import qrs_pkg::*;

   localparam int CW       = COEF_WIDTH;
   localparam int RW       = ROOT_WIDTH;
   // |b*b - 4ac| < 2^(2CW+1)
   localparam int DW       = 2 * CW + 2;
   localparam int MW       = 2 * CW + 1;
   // radicand rounded up to an even width, two bits per root cell
   localparam int RADW     = ((MW + RAD_SHIFT + 1) / 2) * 2;
   localparam int RS       = RADW / 2;
   localparam int NBW      = CW + NEGB_SHIFT + 1;
   localparam int NUMW     = ((NBW > RS + 1) ? NBW : RS + 1) + 1;
   localparam int QW       = NUMW + QUOT_SHIFT;
   localparam int EW       = ((QW > RW) ? QW : RW) + 1;
   localparam int SQ_SIDEW = 2 + 1 + NBW + CW;
   localparam int DV_SIDEW = 2 + ROOT_LANES;

   localparam logic [RW-1:0] ROOT_MAX = {1'b0, {(RW-1){1'b1}}};
   localparam logic [RW-1:0] ROOT_MIN = {1'b1, {(RW-1){1'b0}}};
   localparam logic [EW-1:0] SAT_LIM  = EW'(1) << (RW - 1);

   // Freeze every stage while a finished response waits on a stall
   logic rsp_valid_ff;
   logic en;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = rsp_valid_ff && rsp_stall;

   // ---------------- front end ----------------
   logic                   v0_ff, v1_ff, v2_ff, v3_ff;
   logic signed [CW-1:0]   a0_ff, b0_ff, c0_ff;
   logic signed [CW-1:0]   a1_ff, b1_ff;
   logic signed [2*CW-1:0] bb1_ff, bb1_in, ac1_ff, ac1_in;
   logic signed [DW-1:0]   d2_ff, d2_in;
   logic signed [NBW-1:0]  negb2_ff, negb2_in;
   logic [CW-1:0]          amag2_ff, amag2_in;
   logic                   aneg2_ff, azero2_ff;
   root_kind_type          kind3_ff, kind3_in;
   logic [MW-1:0]          mag3_ff, mag3_in;
   logic signed [NBW-1:0]  negb3_ff;
   logic [CW-1:0]          amag3_ff;
   logic                   aneg3_ff;

   always_comb begin
      bb1_in   = b0_ff * b0_ff;
      ac1_in   = a0_ff * c0_ff;
      d2_in    = DW'(bb1_ff) - (DW'(ac1_ff) <<< 2);
      negb2_in = (-NBW'(b1_ff)) <<< NEGB_SHIFT;
      amag2_in = a1_ff[CW-1] ? CW'(-a1_ff) : CW'(a1_ff);
      mag3_in  = d2_ff[DW-1] ? MW'(-d2_ff) : MW'(d2_ff);
      if (azero2_ff) begin
         kind3_in = KIND_INVALID;
      end else if (d2_ff[DW-1]) begin
         kind3_in = KIND_COMPLEX;
      end else if (d2_ff == '0) begin
         kind3_in = KIND_REPEATED;
      end else begin
         kind3_in = KIND_DISTINCT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff     <= req_coef_a;
         b0_ff     <= req_coef_b;
         c0_ff     <= req_coef_c;
         bb1_ff    <= bb1_in;
         ac1_ff    <= ac1_in;
         a1_ff     <= a0_ff;
         b1_ff     <= b0_ff;
         d2_ff     <= d2_in;
         negb2_ff  <= negb2_in;
         amag2_ff  <= amag2_in;
         aneg2_ff  <= a1_ff[CW-1];
         azero2_ff <= (a1_ff == '0);
         kind3_ff  <= kind3_in;
         mag3_ff   <= mag3_in;
         negb3_ff  <= negb2_ff;
         amag3_ff  <= amag2_ff;
         aneg3_ff  <= aneg2_ff;
      end
   end

   // ---------------- square-root cell chain ----------------
   logic [RS:0]                sq_valid;
   logic [RS:0][RADW-1:0]      sq_rad;
   logic [RS:0][RS+2:0]        sq_rem;
   logic [RS:0][RS-1:0]        sq_root;
   logic [RS:0][SQ_SIDEW-1:0]  sq_side;

   assign sq_valid[0] = v3_ff;
   assign sq_rad[0]   = RADW'({mag3_ff, {RAD_SHIFT{1'b0}}});
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_side[0]  = {kind3_ff, aneg3_ff, negb3_ff, amag3_ff};

   for (genvar k = 0; k < RS; k++) begin : g_sqrt
      qrs_sqrt_cell #(
         .RADW  (RADW),
         .RS    (RS),
         .SIDEW (SQ_SIDEW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (en),
         .in_valid  (sq_valid[k]),
         .in_rad    (sq_rad[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .in_side   (sq_side[k]),
         .out_valid (sq_valid[k+1]),
         .out_rad   (sq_rad[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1]),
         .out_side  (sq_side[k+1])
      );
   end

   // ---------------- numerators ----------------
   root_kind_type          sq_kind;
   logic                   sq_aneg;
   logic signed [NBW-1:0]  sq_negb;
   logic [CW-1:0]          sq_amag;
   logic signed [NUMW-1:0] negb_e, s_e;

   assign sq_kind = root_kind_type'(sq_side[RS][SQ_SIDEW-1 -: 2]);
   assign sq_aneg = sq_side[RS][SQ_SIDEW-3];
   assign sq_negb = sq_side[RS][CW +: NBW];
   assign sq_amag = sq_side[RS][CW-1:0];
   assign negb_e = NUMW'(sq_negb);
   assign s_e    = $signed(NUMW'(sq_root[RS]));

   logic                   v4_ff, v5_ff;
   logic signed [NUMW-1:0] n1_4_ff, n1_4_in, n2_4_ff, n2_4_in;
   logic [RS-1:0]          s4_ff;
   root_kind_type          kind4_ff, kind5_ff;
   logic                   aneg4_ff;
   logic [CW-1:0]          amag4_ff, amag5_ff;
   logic [ROOT_LANES-1:0][QW-1:0] dvd5_ff, dvd5_in;
   logic [ROOT_LANES-1:0]         sgn5_ff, sgn5_in;
   logic [NUMW-1:0]        m1_5, m2_5;

   // complex pair: both real parts are -b/(2a); sqrt goes to the imaginary lane
   always_comb begin
      n1_4_in = (sq_kind == KIND_COMPLEX) ? negb_e : (negb_e + s_e);
      n2_4_in = (sq_kind == KIND_COMPLEX) ? negb_e : (negb_e - s_e);
      m1_5    = n1_4_ff[NUMW-1] ? NUMW'(-n1_4_ff) : NUMW'(n1_4_ff);
      m2_5    = n2_4_ff[NUMW-1] ? NUMW'(-n2_4_ff) : NUMW'(n2_4_ff);
      dvd5_in[0] = {m1_5, {QUOT_SHIFT{1'b0}}};
      dvd5_in[1] = {m2_5, {QUOT_SHIFT{1'b0}}};
      dvd5_in[2] = (kind4_ff == KIND_COMPLEX) ?
                   QW'({s4_ff, {QUOT_SHIFT{1'b0}}}) : '0;
      sgn5_in[0] = n1_4_ff[NUMW-1] ^ aneg4_ff;
      sgn5_in[1] = n2_4_ff[NUMW-1] ^ aneg4_ff;
      sgn5_in[2] = aneg4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= sq_valid[RS];
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_4_ff  <= n1_4_in;
         n2_4_ff  <= n2_4_in;
         s4_ff    <= sq_root[RS];
         kind4_ff <= sq_kind;
         aneg4_ff <= sq_aneg;
         amag4_ff <= sq_amag;
         dvd5_ff  <= dvd5_in;
         sgn5_ff  <= sgn5_in;
         kind5_ff <= kind4_ff;
         amag5_ff <= amag4_ff;
      end
   end

   // ---------------- divider cell chain ----------------
   logic [QW:0]                               dv_valid;
   logic [QW:0][ROOT_LANES-1:0][QW-1:0]       dv_dq;
   logic [QW:0][ROOT_LANES-1:0][CW-1:0]       dv_rem;
   logic [QW:0][CW-1:0]                       dv_div;
   logic [QW:0][DV_SIDEW-1:0]                 dv_side;

   assign dv_valid[0] = v5_ff;
   assign dv_dq[0]    = dvd5_ff;
   assign dv_rem[0]   = '0;
   assign dv_div[0]   = amag5_ff;
   assign dv_side[0]  = {kind5_ff, sgn5_ff};

   for (genvar k = 0; k < QW; k++) begin : g_div
      qrs_div_cell #(
         .QW    (QW),
         .DVW   (CW),
         .SIDEW (DV_SIDEW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (en),
         .in_valid  (dv_valid[k]),
         .in_dq     (dv_dq[k]),
         .in_rem    (dv_rem[k]),
         .in_div    (dv_div[k]),
         .in_side   (dv_side[k]),
         .out_valid (dv_valid[k+1]),
         .out_dq    (dv_dq[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_div   (dv_div[k+1]),
         .out_side  (dv_side[k+1])
      );
   end

   // ---------------- sign and saturate ----------------
   root_kind_type                 dv_kind;
   logic [ROOT_LANES-1:0]         dv_sgn;
   logic [ROOT_LANES-1:0][EW-1:0] mag_e, val_e;
   logic [ROOT_LANES-1:0][RW-1:0] sat6_ff, sat6_in;
   logic [ROOT_LANES-1:0]         clip6_ff, clip6_in;
   root_kind_type                 kind6_ff;
   logic                          v6_ff;

   assign dv_kind = root_kind_type'(dv_side[QW][DV_SIDEW-1 -: 2]);
   assign dv_sgn  = dv_side[QW][ROOT_LANES-1:0];

   always_comb begin
      for (int l = 0; l < ROOT_LANES; l++) begin
         mag_e[l]    = EW'(dv_dq[QW][l]);
         val_e[l]    = dv_sgn[l] ? (-mag_e[l]) : mag_e[l];
         clip6_in[l] = dv_sgn[l] ? (mag_e[l] > SAT_LIM) : (mag_e[l] >= SAT_LIM);
         if (clip6_in[l]) begin
            sat6_in[l] = dv_sgn[l] ? ROOT_MIN : ROOT_MAX;
         end else begin
            sat6_in[l] = val_e[l][RW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= dv_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat6_ff  <= sat6_in;
         clip6_ff <= clip6_in;
         kind6_ff <= dv_kind;
      end
   end

   // ---------------- response register ----------------
   root_kind_type   kind_ff;
   logic [RW-1:0]   r1_ff, i1_ff, r2_ff, i2_ff, r1_in, i1_in, r2_in, i2_in;
   logic            clip_ff, clip_in;
   logic            i2_clip;

   // negating the most negative imaginary part pins it to the top of range
   always_comb begin
      i2_clip = (sat6_ff[2] == ROOT_MIN);
      r1_in   = sat6_ff[0];
      r2_in   = sat6_ff[1];
      i1_in   = sat6_ff[2];
      i2_in   = i2_clip ? ROOT_MAX : (-sat6_ff[2]);
      clip_in = (|clip6_ff) | i2_clip;
      if (kind6_ff == KIND_INVALID) begin
         r1_in   = '0;
         r2_in   = '0;
         i1_in   = '0;
         i2_in   = '0;
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff <= kind6_ff;
         r1_ff   <= r1_in;
         r2_ff   <= r2_in;
         i1_ff   <= i1_in;
         i2_ff   <= i2_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root_kind   = kind_ff;
   assign rsp_first_real  = r1_ff;
   assign rsp_first_imag  = i1_ff;
   assign rsp_second_real = r2_ff;
   assign rsp_second_imag = i2_ff;
   assign rsp_clipped     = clip_ff;

   // ---------------- assertions ----------------
   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_INVALID |->
         rsp_first_real == '0 && rsp_second_real == '0 &&
         rsp_first_imag == '0 && rsp_second_imag == '0 && !rsp_clipped)
      else $error("invalid kind with nonzero roots");

   a_real_no_imag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind != KIND_COMPLEX |->
         rsp_first_imag == '0 && rsp_second_imag == '0)
      else $error("real roots with imaginary part");

   a_conjugate : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_COMPLEX && !rsp_clipped |->
         rsp_second_imag == -rsp_first_imag &&
         rsp_first_real == rsp_second_real)
      else $error("complex pair not conjugate");

   a_repeated : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_REPEATED |->
         rsp_first_real == rsp_second_real)
      else $error("repeated root differs");

endmodule
